/* src/ramao_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helper function of the range assign / min offset unit
// no dependencies

package ramao_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 12;
  localparam int IDX_W       = 11;
  localparam int CMD_W       = 2;
  localparam int OFFS_W      = 14;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int BLK_W       = 5;
  localparam int NBLK        = MAX_ENTRIES >> BLK_W;
  localparam int BID_W       = ADDR_W - BLK_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RAISE  = 2'd1,
    CMD_ASSIGN = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic                     use_raw;
    logic [VALUE_BITS-1:0]    val;
    logic [ADDR_W-1:0]        pos;
    logic signed [OFFS_W-1:0] raw;
  } min_op_t;

  // value minus zero-based position
  function automatic logic signed [OFFS_W-1:0] offs_f(input logic [VALUE_BITS-1:0] val,
                                                      input logic [ADDR_W-1:0] pos);
    offs_f = $signed({{(OFFS_W-VALUE_BITS){1'b0}}, val})
           - $signed({{(OFFS_W-ADDR_W){1'b0}}, pos});
  endfunction

endpackage

/* src/ramao_in_if.sv */
`timescale 1ns / 1ps
// input word channel of the range assign / min offset unit
// depends on ramao_pkg

interface ramao_in_if import ramao_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [IDX_W-1:0]      lo;
  logic [IDX_W-1:0]      hi;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, cmd, lo, hi, value, input ready);
  modport sink   (input valid, cmd, lo, hi, value, output ready);
endinterface

/* src/ramao_out_if.sv */
`timescale 1ns / 1ps
// result word channel of the range assign / min offset unit
// depends on ramao_pkg

interface ramao_out_if import ramao_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OFFS_W-1:0] min_offset;
  logic                     changed;
  logic [IDX_W-1:0]         border;

  modport source (output valid, min_offset, changed, border, input ready);
  modport sink   (input valid, min_offset, changed, border, output ready);
endinterface

/* src/ramao_cfg_if.sv */
`timescale 1ns / 1ps
// configuration write channel carrying the used length word
// depends on ramao_pkg

interface ramao_cfg_if import ramao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/range_assign_min_offset_tree_unit.sv */
`timescale 1ns / 1ps
// per word: search probes, each a ram read then a compare; then the block fill, where a partially
// covered block is swept (one entry ram read/write and one min unit step per entry) and a fully
// covered block gets its tag and minimum directly; then the minimum pass over full blocks and a tail sweep
// throughput: one word at a time, next word taken once the result sits in the output register
// reset: block tags cleared, used length 1024, entries undefined until loaded, no clearing pass
// depends on ramao_pkg, the channel interfaces, ramao_ctrl, ramao_entry_mem, ramao_min_unit

module range_assign_min_offset_tree_unit import ramao_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ramao_in_if.sink   in_i,
  ramao_out_if.source out_o,
  ramao_cfg_if.sink  cfg_i
);

  logic [IDX_W-1:0]         used_length_q;
  logic                     res_valid, res_ready, res_changed;
  logic signed [OFFS_W-1:0] res_min_offset;
  logic [IDX_W-1:0]         res_border;
  mem_req_t                 mem_req;
  logic [VALUE_BITS-1:0]    mem_rdata;
  min_op_t                  min_op;
  logic signed [OFFS_W-1:0] min_acc;

  logic                     out_valid_q;
  logic signed [OFFS_W-1:0] out_min_offset_q;
  logic                     out_changed_q;
  logic [IDX_W-1:0]         out_border_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_length_q <= IDX_W'(MAX_ENTRIES);
    end else if (cfg_i.valid) begin
      used_length_q <= cfg_i.data;
    end
  end

  ramao_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_i.valid),
    .req_ready_o      (in_i.ready),
    .cmd_i            (in_i.cmd),
    .lo_i             (in_i.lo),
    .hi_i             (in_i.hi),
    .value_i          (in_i.value),
    .used_length_i    (used_length_q),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_min_offset_o (res_min_offset),
    .res_changed_o    (res_changed),
    .res_border_o     (res_border),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .min_op_o         (min_op),
    .min_acc_i        (min_acc)
  );

  ramao_entry_mem u_entry_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ramao_min_unit u_min_unit (
    .clk_i (clk_i),
    .op_i  (min_op),
    .acc_o (min_acc)
  );

  // output word register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_min_offset_q <= res_min_offset;
      out_changed_q    <= res_changed;
      out_border_q     <= res_border;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.min_offset = out_min_offset_q;
  assign out_o.changed    = out_changed_q;
  assign out_o.border     = out_border_q;

  a_border_implies_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.border != '0) |-> out_o.changed)
    else $error("border reported without a change");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("sequencer took a word while still idle");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> !in_i.ready)
    else $error("entry ram written while idle");

  a_result_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_i.ready)
    else $error("result offered while idle");

endmodule

/* src/ramao_entry_mem.sv */
`timescale 1ns / 1ps
// entry store: one write port and one registered read port
// depends on ramao_pkg

module ramao_entry_mem import ramao_pkg::*; (
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ramao_min_unit.sv */
`timescale 1ns / 1ps
// shared offset and running minimum unit
// depends on ramao_pkg

module ramao_min_unit import ramao_pkg::*; (
  input  logic                     clk_i,
  input  min_op_t                  op_i,
  output logic signed [OFFS_W-1:0] acc_o
);

  logic signed [OFFS_W-1:0] acc_q, acc_d, operand;

  always_comb begin
    operand = op_i.use_raw ? op_i.raw : offs_f(op_i.val, op_i.pos);
    acc_d   = acc_q;
    if (op_i.en) begin
      if (op_i.clr || (operand < acc_q)) begin
        acc_d = operand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* src/ramao_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: search probes, block fill with lazy block tags, minimum pass
// depends on ramao_pkg; drives ramao_entry_mem and ramao_min_unit

module ramao_ctrl import ramao_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [IDX_W-1:0]         lo_i,
  input  logic [IDX_W-1:0]         hi_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  input  logic [IDX_W-1:0]         used_length_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic signed [OFFS_W-1:0] res_min_offset_o,
  output logic                     res_changed_o,
  output logic [IDX_W-1:0]         res_border_o,
  output mem_req_t                 mem_req_o,
  input  logic [VALUE_BITS-1:0]    mem_rdata_i,
  output min_op_t                  min_op_o,
  input  logic signed [OFFS_W-1:0] min_acc_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_FILL_BLK,
    S_SWEEP,
    S_SWEEP_END,
    S_GMIN,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [IDX_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [IDX_W-1:0]      a_q, a_d, b_q, b_d, k_q, k_d, mid_q, mid_d;
  logic                  first_q, first_d;
  logic [ADDR_W-1:0]     pa_q, pa_d, pb_q, pb_d;
  logic [BID_W-1:0]      blk_q, blk_d;
  logic [BLK_W:0]        j_q, j_d;
  logic [BLK_W-1:0]      jlast_q, jlast_d;
  logic                  wr_q, wr_d;
  logic [BID_W:0]        gb_q, gb_d;
  logic                  changed_q, changed_d;
  logic [IDX_W-1:0]      border_q, border_d;

  // block table
  logic [NBLK-1:0]          tag_v_q;
  logic [VALUE_BITS-1:0]    tag_val_q [NBLK];
  logic signed [OFFS_W-1:0] bmin_q [NBLK];
  logic                     blk_we, blk_tag_set;
  logic signed [OFFS_W-1:0] blk_min_wdata;

  logic [IDX_W-1:0]      n_w, hs_w;
  logic [BID_W:0]        nfull_w;
  logic [BLK_W-1:0]      ntail_w;
  logic [ADDR_W-1:0]     lo_m1_w, mid_addr_w, spos_w;
  logic [IDX_W:0]        mid_sum_w;
  logic [IDX_W-1:0]      mid_calc_w, mid_w, na_w, nb_w, nk_w;
  logic [BID_W-1:0]      tag_idx_w;
  logic [VALUE_BITS-1:0] cur_w, newv_w;
  logic [BLK_W-1:0]      jm1_w;
  logic [BLK_W:0]        j_end_w;
  logic                  lt_w, in_rng_w, full_w, last_blk_w;

  always_comb begin
    if (used_length_i == '0) begin
      n_w = IDX_W'(1);
    end else if (used_length_i > IDX_W'(MAX_ENTRIES)) begin
      n_w = IDX_W'(MAX_ENTRIES);
    end else begin
      n_w = used_length_i;
    end
  end

  assign nfull_w    = n_w[BLK_W +: BID_W+1];
  assign ntail_w    = n_w[BLK_W-1:0];
  assign hs_w       = (hi_q > n_w) ? n_w : hi_q;
  assign lo_m1_w    = ADDR_W'(lo_q - 1'b1);
  assign mid_sum_w  = {1'b0, a_q} + {1'b0, b_q};
  assign mid_calc_w = mid_sum_w[IDX_W:1];
  assign mid_w      = first_q ? lo_q : mid_calc_w;
  assign mid_addr_w = ADDR_W'(mid_q - 1'b1);
  assign tag_idx_w  = (state_q == S_PROBE_CMP) ? mid_addr_w[ADDR_W-1:BLK_W] : blk_q;
  assign cur_w      = tag_v_q[tag_idx_w] ? tag_val_q[tag_idx_w] : mem_rdata_i;
  assign lt_w       = cur_w < v_q;
  assign na_w       = lt_w ? IDX_W'(mid_q + 1'b1) : a_q;
  assign nb_w       = lt_w ? b_q : IDX_W'(mid_q - 1'b1);
  assign nk_w       = lt_w ? mid_q : k_q;
  assign jm1_w      = BLK_W'(j_q - 1'b1);
  assign j_end_w    = (BLK_W+1)'(jlast_q) + 1'b1;
  assign spos_w     = {blk_q, jm1_w};
  assign in_rng_w   = (spos_w >= pa_q) && (spos_w <= pb_q);
  assign newv_w     = in_rng_w ? v_q : cur_w;
  assign full_w     = ((blk_q != pa_q[ADDR_W-1:BLK_W]) || (pa_q[BLK_W-1:0] == '0))
                   && ((blk_q != pb_q[ADDR_W-1:BLK_W]) || (pb_q[BLK_W-1:0] == '1));
  assign last_blk_w = blk_q == pb_q[ADDR_W-1:BLK_W];

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    v_d           = v_q;
    a_d           = a_q;
    b_d           = b_q;
    k_d           = k_q;
    mid_d         = mid_q;
    first_d       = first_q;
    pa_d          = pa_q;
    pb_d          = pb_q;
    blk_d         = blk_q;
    j_d           = j_q;
    jlast_d       = jlast_q;
    wr_d          = wr_q;
    gb_d          = gb_q;
    changed_d     = changed_q;
    border_d      = border_q;
    req_ready_o   = 1'b0;
    res_valid_o   = 1'b0;
    mem_req_o     = '0;
    min_op_o      = '0;
    blk_we        = 1'b0;
    blk_tag_set   = 1'b0;
    blk_min_wdata = min_acc_i;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d     = cmd_i;
          lo_d      = lo_i;
          hi_d      = hi_i;
          v_d       = value_i;
          changed_d = 1'b0;
          border_d  = '0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        gb_d    = '0;
        state_d = S_GMIN;
        case (cmd_q)
          CMD_LOAD: begin
            if ((lo_q != '0) && (lo_q <= n_w)) begin
              pa_d      = lo_m1_w;
              pb_d      = lo_m1_w;
              blk_d     = lo_m1_w[ADDR_W-1:BLK_W];
              changed_d = 1'b1;
              state_d   = S_FILL_BLK;
            end
          end
          CMD_RAISE: begin
            if ((lo_q != '0) && (lo_q <= hs_w)) begin
              a_d     = lo_q;
              b_d     = hs_w;
              k_d     = lo_q;
              first_d = 1'b1;
              state_d = S_PROBE_RD;
            end
          end
          CMD_ASSIGN: begin
            if ((lo_q != '0) && (lo_q <= hs_w)) begin
              pa_d      = lo_m1_w;
              pb_d      = ADDR_W'(hs_w - 1'b1);
              blk_d     = lo_m1_w[ADDR_W-1:BLK_W];
              changed_d = 1'b1;
              state_d   = S_FILL_BLK;
            end
          end
          default: begin
            state_d = S_GMIN;
          end
        endcase
      end
      S_PROBE_RD: begin
        mid_d           = mid_w;
        mem_req_o.raddr = ADDR_W'(mid_w - 1'b1);
        state_d         = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (first_q) begin
          if (lt_w) begin
            first_d = 1'b0;
            state_d = S_PROBE_RD;
          end else begin
            gb_d    = '0;
            state_d = S_GMIN;
          end
        end else begin
          a_d = na_w;
          b_d = nb_w;
          k_d = nk_w;
          if (na_w <= nb_w) begin
            state_d = S_PROBE_RD;
          end else begin
            pa_d      = lo_m1_w;
            pb_d      = ADDR_W'(nk_w - 1'b1);
            blk_d     = lo_m1_w[ADDR_W-1:BLK_W];
            changed_d = 1'b1;
            border_d  = nk_w;
            state_d   = S_FILL_BLK;
          end
        end
      end
      S_FILL_BLK: begin
        if (full_w) begin
          // whole block covered: set tag, minimum sits at the block's last entry
          blk_we        = 1'b1;
          blk_tag_set   = 1'b1;
          blk_min_wdata = offs_f(v_q, {blk_q, {BLK_W{1'b1}}});
          if (last_blk_w) begin
            gb_d    = '0;
            state_d = S_GMIN;
          end else begin
            blk_d = BID_W'(blk_q + 1'b1);
          end
        end else begin
          j_d     = '0;
          jlast_d = '1;
          wr_d    = 1'b1;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (j_q <= {1'b0, jlast_q}) begin
          mem_req_o.raddr = {blk_q, j_q[BLK_W-1:0]};
        end
        if (j_q != '0) begin
          min_op_o.en  = 1'b1;
          min_op_o.val = wr_q ? newv_w : cur_w;
          min_op_o.pos = spos_w;
          min_op_o.clr = (j_q == (BLK_W+1)'(1)) && (wr_q || (nfull_w == '0));
          if (wr_q) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = spos_w;
            mem_req_o.wdata = newv_w;
          end
        end
        if (j_q == j_end_w) begin
          state_d = S_SWEEP_END;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SWEEP_END: begin
        if (wr_q) begin
          // rebuilt block: tag pushed into entries, store fresh minimum
          blk_we        = 1'b1;
          blk_tag_set   = 1'b0;
          blk_min_wdata = min_acc_i;
          if (last_blk_w) begin
            gb_d    = '0;
            state_d = S_GMIN;
          end else begin
            blk_d   = BID_W'(blk_q + 1'b1);
            state_d = S_FILL_BLK;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_GMIN: begin
        if (gb_q < nfull_w) begin
          min_op_o.en      = 1'b1;
          min_op_o.use_raw = 1'b1;
          min_op_o.raw     = bmin_q[gb_q[BID_W-1:0]];
          min_op_o.clr     = gb_q == '0;
          gb_d             = gb_q + 1'b1;
        end else if (ntail_w != '0) begin
          blk_d   = nfull_w[BID_W-1:0];
          j_d     = '0;
          jlast_d = BLK_W'(ntail_w - 1'b1);
          wr_d    = 1'b0;
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      v_q       <= '0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      mid_q     <= '0;
      first_q   <= 1'b0;
      pa_q      <= '0;
      pb_q      <= '0;
      blk_q     <= '0;
      j_q       <= '0;
      jlast_q   <= '0;
      wr_q      <= 1'b0;
      gb_q      <= '0;
      changed_q <= 1'b0;
      border_q  <= '0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      v_q       <= v_d;
      a_q       <= a_d;
      b_q       <= b_d;
      k_q       <= k_d;
      mid_q     <= mid_d;
      first_q   <= first_d;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      blk_q     <= blk_d;
      j_q       <= j_d;
      jlast_q   <= jlast_d;
      wr_q      <= wr_d;
      gb_q      <= gb_d;
      changed_q <= changed_d;
      border_q  <= border_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_v_q <= '0;
    end else if (blk_we) begin
      tag_v_q[blk_q] <= blk_tag_set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      bmin_q[blk_q] <= blk_min_wdata;
      if (blk_tag_set) begin
        tag_val_q[blk_q] <= v_q;
      end
    end
  end

  assign res_min_offset_o = min_acc_i;
  assign res_changed_o    = changed_q;
  assign res_border_o     = border_q;

endmodule

/* bench/tb_range_assign_min_offset_tree_unit.sv */
`timescale 1ns / 1ps
// self-checking bench for range_assign_min_offset_tree_unit: directed words, back-pressure,
// sender pause and random staircase traffic, each result checked against an array mirror
// depends on ramao_pkg, ramao_in_if, ramao_out_if, ramao_cfg_if and the unit itself

module tb_range_assign_min_offset_tree_unit import ramao_pkg::*; ();

  localparam logic [CMD_W-1:0]      CMD_UNUSED     = 2'd3;
  localparam logic [VALUE_BITS-1:0] VALUE_NONE     = {VALUE_BITS{1'b1}};
  localparam int                    IDX_ALL_ONES   = (1 << IDX_W) - 1;
  localparam int                    RANDOM_WORDS   = 1200;
  localparam int                    WATCHDOG_LIMIT = 20000;
  localparam int                    MAX_REPORTS    = 30;

  typedef struct packed {
    logic signed [OFFS_W-1:0] min_offset;
    logic                     changed;
    logic [IDX_W-1:0]         border;
  } result_t;

  logic clk_i;
  logic rst_ni;

  ramao_in_if  in_if ();
  ramao_out_if out_if ();
  ramao_cfg_if cfg_if ();

  range_assign_min_offset_tree_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  logic [VALUE_BITS-1:0] array_copy [1:MAX_ENTRIES];
  logic [IDX_W-1:0]      length_copy;
  result_t               queued_results [$];

  int  mismatch_count = 0;
  int  word_count     = 0;
  int  length_writes  = 0;
  int  raise_moves    = 0;
  int  still_words    = 0;
  int  idle_cycles    = 0;
  int  sink_hold      = 0;
  int  sink_stall     = 0;
  bit  src_jitter     = 1'b1;
  bit  sink_jitter    = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int active_length();
    if (length_copy == 0) return 1;
    if (int'(length_copy) > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(length_copy);
  endfunction

  function automatic result_t update_array(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] lo,
                                           input logic [IDX_W-1:0] hi,
                                           input logic [VALUE_BITS-1:0] value);
    result_t res;
    int      n, top, first, a, b, mid, last_low, best, cur;
    n        = active_length();
    first    = int'(lo);
    top      = (int'(hi) > n) ? n : int'(hi);
    last_low = 0;
    res      = '0;
    if (cmd == CMD_LOAD) begin
      if (first >= 1 && first <= n) begin
        array_copy[first] = value;
        res.changed = 1'b1;
      end
    end else if ((cmd == CMD_RAISE || cmd == CMD_ASSIGN) && first >= 1 && first <= top) begin
      if (cmd == CMD_ASSIGN) begin
        for (int i = first; i <= top; i++) array_copy[i] = value;
        res.changed = 1'b1;
      end else if (array_copy[first] < value) begin
        // binary search for the last entry below the new value
        a        = first;
        b        = top;
        last_low = first;
        while (a <= b) begin
          mid = (a + b) / 2;
          if (array_copy[mid] < value) begin
            last_low = mid;
            a        = mid + 1;
          end else begin
            b = mid - 1;
          end
        end
        for (int i = first; i <= last_low; i++) array_copy[i] = value;
        res.changed = 1'b1;
      end
    end
    best = 0;
    for (int i = 1; i <= n; i++) begin
      cur = int'(array_copy[i]) - i + 1;
      if (i == 1 || cur < best) best = cur;
    end
    res.min_offset = OFFS_W'(best);
    res.border     = IDX_W'(last_low);
    if (last_low != 0) raise_moves++;
    if (!res.changed) still_words++;
    return res;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input int lo, input int hi,
                           input int value);
    int gap;
    gap = src_jitter ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.cmd   = cmd;
    in_if.lo    = IDX_W'(lo);
    in_if.hi    = IDX_W'(hi);
    in_if.value = VALUE_BITS'(value);
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    queued_results.insert(queued_results.size(),
                          update_array(cmd, IDX_W'(lo), IDX_W'(hi), VALUE_BITS'(value)));
    word_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (queued_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input int len);
    drain_results();
    @(negedge clk_i);
    cfg_if.data  = IDX_W'(len);
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    length_copy = IDX_W'(len);
    length_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // raise that keeps a non-decreasing array non-decreasing
  task automatic random_raise(input int n);
    int lo, hi, top, span, v, r;
    lo  = $urandom_range(1, n);
    top = $urandom_range(lo, n);
    hi  = ($urandom_range(0, 7) == 0) ? $urandom_range(n, IDX_ALL_ONES) : top;
    if (hi > n) top = n;
    r   = $urandom_range(0, 9);
    if (r == 0) begin
      v = VALUE_NONE;
    end else if (r == 1) begin
      v = $urandom_range(0, array_copy[lo]);
    end else begin
      span = int'(array_copy[top]) - int'(array_copy[lo]) + 64;
      v    = int'(array_copy[lo]) + $urandom_range(1, span);
      if (v > VALUE_NONE) v = VALUE_NONE;
    end
    send_word(CMD_RAISE, lo, hi, v);
  endtask

  task automatic build_staircase(input int n);
    int level, cut;
    level = $urandom_range(0, 2000);
    send_word(CMD_ASSIGN, 1, n, level);
    repeat ($urandom_range(1, 4)) begin
      cut   = $urandom_range(1, n);
      level = level + $urandom_range(0, 300);
      if (level > VALUE_NONE - 1) level = VALUE_NONE - 1;
      send_word(CMD_ASSIGN, cut, n, level);
    end
  endtask

  task automatic test_small_length();
    write_length(0);
    send_word(CMD_LOAD, 1, 0, 0);
    send_word(CMD_LOAD, 0, 0, 77);
    send_word(CMD_LOAD, 2, 0, 77);
    send_word(CMD_UNUSED, 1, 1, 99);
    send_word(CMD_RAISE, 1, 1, VALUE_NONE);
    send_word(CMD_RAISE, 1, 1, VALUE_NONE);
    send_word(CMD_ASSIGN, 1, 0, 5);
    write_length(1);
    send_word(CMD_RAISE, 1, IDX_ALL_ONES, 0);
  endtask

  task automatic test_full_length();
    write_length(IDX_ALL_ONES);
    send_word(CMD_ASSIGN, 1, IDX_ALL_ONES, VALUE_NONE);
    send_word(CMD_LOAD, MAX_ENTRIES, 0, 0);
    send_word(CMD_LOAD, MAX_ENTRIES + 1, 0, 1);
    send_word(CMD_LOAD, IDX_ALL_ONES, IDX_ALL_ONES, 1);
    send_word(CMD_ASSIGN, 0, 5, 7);
    send_word(CMD_RAISE, 5, 4, 300);
    send_word(CMD_ASSIGN, 1, MAX_ENTRIES, 0);
    send_word(CMD_ASSIGN, MAX_ENTRIES / 2 + 1, MAX_ENTRIES, 100);
    send_word(CMD_RAISE, 1, MAX_ENTRIES, 50);
    send_word(CMD_RAISE, 1, IDX_ALL_ONES, VALUE_NONE);
    send_word(CMD_RAISE, 300, 600, VALUE_NONE);
    send_word(CMD_LOAD, 1, 0, VALUE_NONE);
    send_word(CMD_RAISE, MAX_ENTRIES, MAX_ENTRIES, 0);
  endtask

  task automatic test_output_backpressure();
    src_jitter = 1'b0;
    sink_hold  = 1000;
    repeat (6) random_raise(active_length());
    drain_results();
    src_jitter = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (4) random_raise(active_length());
    drain_results();
    repeat (4) random_raise(active_length());
  endtask

  task automatic test_random_traffic();
    int r, len, n;
    while (word_count < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 50)      len = $urandom_range(1, 40);
      else if (r < 75) len = $urandom_range(41, 300);
      else if (r < 88) len = MAX_ENTRIES;
      else if (r < 92) len = 0;
      else if (r < 96) len = IDX_ALL_ONES;
      else             len = $urandom_range(1, 2);
      write_length(len);
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      n = active_length();
      build_staircase(n);
      repeat ($urandom_range(30, 80)) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          random_raise(n);
        end else if (r < 90) begin
          send_word(CMD_W'($urandom_range(0, 3)), $urandom_range(0, IDX_ALL_ONES),
                    $urandom_range(0, IDX_ALL_ONES), $urandom_range(0, VALUE_NONE));
        end else if (r < 95) begin
          send_word(CMD_LOAD, $urandom_range(1, n), $urandom_range(0, IDX_ALL_ONES),
                    $urandom_range(0, VALUE_NONE));
        end else begin
          len = $urandom_range(1, n);
          send_word(CMD_ASSIGN, len, $urandom_range(len, n), $urandom_range(0, VALUE_NONE));
        end
      end
    end
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
  endtask

  always @(negedge clk_i) begin : sink_ready_drv
    logic take;
    take = 1'b1;
    if (sink_hold > 0) begin
      sink_hold--;
      take = 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      take = 1'b0;
    end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
      sink_stall = pick_gap();
      take       = (sink_stall == 0);
    end
    out_if.ready = take;
  end

  task automatic flag_field(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (queued_results.size() == 0) begin
        mismatch_count++;
        $error("result word with no expectation pending");
      end else begin
        want = queued_results.pop_front();
        if (out_if.min_offset !== want.min_offset)
          flag_field("min_offset", $signed(want.min_offset), $signed(out_if.min_offset));
        if (out_if.changed !== want.changed)
          flag_field("changed", want.changed, out_if.changed);
        if (out_if.border !== want.border)
          flag_field("border", want.border, out_if.border);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("range_assign_min_offset_tree_unit verification failed");
      $finish;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_LOAD;
    in_if.lo     = '0;
    in_if.hi     = '0;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    length_copy  = IDX_W'(MAX_ENTRIES);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_small_length();
    test_full_length();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    drain_results();
    repeat (300) @(posedge clk_i);
    if (queued_results.size() != 0) begin
      mismatch_count += queued_results.size();
      $error("%0d expected results never arrived", queued_results.size());
    end
    $display("run covered %0d words over %0d length settings, including stalls and gaps",
             word_count, length_writes);
    $display("%0d raises moved a border, %0d words left the array as it was",
             raise_moves, still_words);
    if (mismatch_count == 0)
      $display("range_assign_min_offset_tree_unit verification clean");
    else
      $display("range_assign_min_offset_tree_unit verification failed");
    $finish;
  end

endmodule

/* range_assign_min_offset_tree_unit.f */
src/ramao_pkg.sv
src/ramao_in_if.sv
src/ramao_out_if.sv
src/ramao_cfg_if.sv
src/ramao_entry_mem.sv
src/ramao_min_unit.sv
src/ramao_ctrl.sv
src/range_assign_min_offset_tree_unit.sv
bench/tb_range_assign_min_offset_tree_unit.sv
